// ===== src/pm_pkg.sv =====
package pm_pkg;

  // Default and largest supported store depth.
  localparam int PM_MAX_TERMS   = 32;
  localparam int PM_MAX_LIMIT   = 256;

  localparam int PM_COEFF_W     = 16;
  localparam int PM_SUM_W       = 40;
  localparam int PM_POW_W       = 6;
  localparam int PM_ADDR_W      = $clog2(PM_MAX_LIMIT);
  localparam int PM_CNT_W       = $clog2(PM_MAX_LIMIT + 1);
  localparam int PM_QUEUE_DEPTH = 4;

  // Input func codes.
  typedef enum logic {
    SEL_P = 1'b0,
    SEL_Q = 1'b1
  } sel_t;

  // Command from the front part to the back part.
  typedef struct packed {
    logic                         wr;
    sel_t                         sel;
    logic [PM_ADDR_W-1:0]         addr;
    logic signed [PM_COEFF_W-1:0] data;
    logic                         run;
    logic [PM_CNT_W-1:0]          np;
    logic [PM_CNT_W-1:0]          nq;
    logic                         trunc;
  } pm_cmd_t;

endpackage

// ===== src/pm_front.sv =====
module pm_front
  import pm_pkg::*;
#(
  parameter int MAX_TERMS = PM_MAX_TERMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [PM_COEFF_W-1:0] in_coeff_value,
  input  logic                         in_last_coeff,
  output pm_cmd_t                      cmd,
  output logic                         cmd_valid,
  input  logic                         cmd_ready
);

  localparam int CW = $clog2(MAX_TERMS + 1);

  logic [CW-1:0] p_cnt_r, p_cnt_nxt;
  logic [CW-1:0] q_cnt_r, q_cnt_nxt;
  logic          closed_r, closed_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] p_base;
  logic [CW-1:0] q_base;
  logic          ovf_base;
  logic          restart;
  logic          room;
  logic          accept;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  always_comb begin
    restart    = (sel_t'(in_func) == SEL_P) && closed_r;
    p_base     = restart ? '0 : p_cnt_r;
    q_base     = restart ? '0 : q_cnt_r;
    ovf_base   = restart ? 1'b0 : ovf_r;
    room       = 1'b0;
    p_cnt_nxt  = p_base;
    q_cnt_nxt  = q_base;
    ovf_nxt    = ovf_base;
    closed_nxt = closed_r;
    cmd        = '0;
    cmd.sel    = sel_t'(in_func);
    cmd.data   = in_coeff_value;
    if (sel_t'(in_func) == SEL_P) begin
      room       = p_base < CW'(MAX_TERMS);
      cmd.wr     = room;
      cmd.addr   = PM_ADDR_W'(p_base);
      p_cnt_nxt  = p_base + CW'(room);
      ovf_nxt    = ovf_base | ~room;
      closed_nxt = in_last_coeff;
    end else begin
      room       = q_cnt_r < CW'(MAX_TERMS);
      cmd.wr     = room;
      cmd.addr   = PM_ADDR_W'(q_cnt_r);
      q_cnt_nxt  = q_cnt_r + CW'(room);
      ovf_nxt    = ovf_r | ~room;
      closed_nxt = 1'b1;
      if (in_last_coeff) begin
        // Close the pair: hand counts to the engine, start fresh.
        cmd.run    = 1'b1;
        cmd.np     = PM_CNT_W'(p_cnt_r);
        cmd.nq     = PM_CNT_W'(q_cnt_nxt);
        cmd.trunc  = ovf_nxt;
        p_cnt_nxt  = '0;
        q_cnt_nxt  = '0;
        ovf_nxt    = 1'b0;
        closed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_cnt_r  <= '0;
      q_cnt_r  <= '0;
      closed_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (accept) begin
      p_cnt_r  <= p_cnt_nxt;
      q_cnt_r  <= q_cnt_nxt;
      closed_r <= closed_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

// ===== src/pm_queue.sv =====
module pm_queue
  import pm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  pm_cmd_t push_cmd,
  input  logic    push_valid,
  output logic    push_ready,
  output pm_cmd_t pop_cmd,
  output logic    pop_valid,
  input  logic    pop_ready
);

  localparam int DEPTH = PM_QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  pm_cmd_t         slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [NW-1:0]   cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = cnt_r != NW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + NW'(push) - NW'(pop);
    end
  end

endmodule

// ===== src/pm_back.sv =====
module pm_back
  import pm_pkg::*;
#(
  parameter int MAX_TERMS = PM_MAX_TERMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pm_cmd_t               cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PM_SUM_W-1:0]   out_product_coeff,
  output logic [PM_POW_W-1:0]   out_power,
  output logic                  out_last_term,
  output logic                  out_truncated
);

  localparam int AW     = $clog2(MAX_TERMS);
  localparam int CW     = $clog2(MAX_TERMS + 1);
  localparam int KW     = CW + 1;
  localparam int PROD_W = 2 * PM_COEFF_W;

  typedef struct packed {
    logic                first;
    logic                last;
    logic [PM_POW_W-1:0] power;
    logic                last_term;
  } tag_t;

  logic signed [PM_COEFF_W-1:0] p_mem [MAX_TERMS];
  logic signed [PM_COEFF_W-1:0] q_mem [MAX_TERMS];

  // Job and sequencer registers.
  logic          run_r;
  logic [CW-1:0] np_r;
  logic [CW-1:0] nq_r;
  logic          pzero_r;
  logic          trunc_r;
  logic [KW-1:0] lastk_r;
  logic [KW-1:0] k_r;
  logic [AW-1:0] i_r;
  logic [AW-1:0] ihi_r;
  logic          first_r;

  // Pipeline stages.
  logic                         s0_v_r, s1_v_r, s2_v_r;
  logic [AW-1:0]                s0_i_r, s0_j_r;
  tag_t                         s0_tag_r, s1_tag_r, s2_tag_r;
  logic signed [PM_COEFF_W-1:0] p_rd_r, q_rd_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic [PM_SUM_W-1:0]          acc_r;
  logic                         out_valid_r;
  logic [PM_SUM_W-1:0]          out_coeff_r;
  logic [PM_POW_W-1:0]          out_power_r;
  logic                         out_last_r;
  logic                         out_trunc_r;

  logic                         adv;
  logic                         busy;
  logic                         pop;
  logic [CW-1:0]                np_in;
  logic                         np_zero;
  logic [CW-1:0]                np_eff;
  logic [CW-1:0]                nq_in;
  logic                         end_k;
  logic                         end_job;
  logic [KW-1:0]                k_inc;
  logic [AW-1:0]                ilo_nxt;
  logic [AW-1:0]                ihi_nxt;
  logic [AW-1:0]                j_cur;
  logic signed [PM_COEFF_W-1:0] p_op;
  logic [PM_SUM_W-1:0]          sum;

  assign adv       = !out_valid_r || out_ready;
  assign busy      = run_r || s0_v_r || s1_v_r || s2_v_r;
  assign cmd_ready = !busy;
  assign pop       = cmd_valid && !busy;

  assign np_in   = cmd.np[CW-1:0];
  assign nq_in   = cmd.nq[CW-1:0];
  assign np_zero = np_in == '0;
  assign np_eff  = np_zero ? CW'(1) : np_in;

  // Index window for the next power: i from max(0, k-nq+1) to min(k, np-1).
  assign end_k   = i_r == ihi_r;
  assign end_job = end_k && (k_r == lastk_r);
  assign k_inc   = k_r + KW'(1);
  assign ilo_nxt = (k_inc >= KW'(nq_r)) ? AW'(k_inc - KW'(nq_r) + KW'(1)) : '0;
  assign ihi_nxt = (k_inc < KW'(np_r)) ? AW'(k_inc) : AW'(np_r - CW'(1));
  assign j_cur   = AW'(k_r - KW'(i_r));

  assign p_op = pzero_r ? '0 : p_rd_r;
  assign sum  = (s2_tag_r.first ? '0 : acc_r)
              + {{(PM_SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (pop && cmd.wr && cmd.sel == SEL_P) begin
      p_mem[cmd.addr[AW-1:0]] <= cmd.data;
    end
    if (adv) begin
      p_rd_r <= p_mem[s0_i_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.wr && cmd.sel == SEL_Q) begin
      q_mem[cmd.addr[AW-1:0]] <= cmd.data;
    end
    if (adv) begin
      q_rd_r <= q_mem[s0_j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && cmd.run) begin
        run_r <= 1'b1;
      end else if (run_r && adv && end_job) begin
        run_r <= 1'b0;
      end
      if (adv) begin
        s0_v_r      <= run_r;
        s1_v_r      <= s0_v_r;
        s2_v_r      <= s1_v_r;
        out_valid_r <= s2_v_r && s2_tag_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.run) begin
      np_r    <= np_eff;
      nq_r    <= nq_in;
      pzero_r <= np_zero;
      trunc_r <= cmd.trunc;
      lastk_r <= KW'(np_eff) + KW'(nq_in) - KW'(2);
      k_r     <= '0;
      i_r     <= '0;
      ihi_r   <= '0;
      first_r <= 1'b1;
    end else if (run_r && adv) begin
      if (end_k) begin
        k_r     <= k_inc;
        i_r     <= ilo_nxt;
        ihi_r   <= ihi_nxt;
        first_r <= 1'b1;
      end else begin
        i_r     <= i_r + AW'(1);
        first_r <= 1'b0;
      end
    end
    if (adv) begin
      s0_i_r             <= i_r;
      s0_j_r             <= j_cur;
      s0_tag_r.first     <= first_r;
      s0_tag_r.last      <= end_k;
      s0_tag_r.power     <= PM_POW_W'(k_r);
      s0_tag_r.last_term <= end_job;
      s1_tag_r           <= s0_tag_r;
      s2_tag_r           <= s1_tag_r;
      prod_r             <= p_op * q_rd_r;
      if (s2_v_r) begin
        acc_r <= sum;
      end
      if (s2_v_r && s2_tag_r.last) begin
        out_coeff_r <= sum;
        out_power_r <= s2_tag_r.power;
        out_last_r  <= s2_tag_r.last_term;
        out_trunc_r <= trunc_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_coeff = out_coeff_r;
  assign out_power         = out_power_r;
  assign out_last_term     = out_last_r;
  assign out_truncated     = out_trunc_r;

endmodule

// ===== src/polynomial_multiply.sv =====
// Coefficient items are taken one per cycle while the command queue has room; each costs
// one queue slot. The item carrying the last Q coefficient starts a product pass: one
// multiply-accumulate per coefficient pair on one shared 16x16 multiplier. Results pass
// from the sequencer through stages s0, s1 and s2 to the output register; a 4-entry
// command queue lets loading of the next pair proceed during a pass until it fills.
// Reset (rst_n low, synchronous) empties the queue, clears counts, flags and valids.
module polynomial_multiply
  import pm_pkg::*;
#(
  parameter int MAX_TERMS = PM_MAX_TERMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [PM_COEFF_W-1:0] in_coeff_value,
  input  logic                         in_last_coeff,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PM_SUM_W-1:0]   out_product_coeff,
  output logic [PM_POW_W-1:0]          out_power,
  output logic                         out_last_term,
  output logic                         out_truncated
);

  // Front: count coefficients per polynomial, pick store addresses, drop overflow,
  // and close a pair on the last Q item.
  pm_cmd_t front_cmd;
  logic    front_valid;
  logic    front_ready;

  // Back: write stores, then sweep the product when a run command arrives.
  pm_cmd_t back_cmd;
  logic    back_valid;
  logic    back_ready;
  logic [PM_SUM_W-1:0] product_bits;

  pm_front #(
    .MAX_TERMS (MAX_TERMS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_coeff_value (in_coeff_value),
    .in_last_coeff  (in_last_coeff),
    .cmd            (front_cmd),
    .cmd_valid      (front_valid),
    .cmd_ready      (front_ready)
  );

  // Decouple the item rate from the engine.
  pm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  pm_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (back_cmd),
    .cmd_valid         (back_valid),
    .cmd_ready         (back_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_coeff (product_bits),
    .out_power         (out_power),
    .out_last_term     (out_last_term),
    .out_truncated     (out_truncated)
  );

  assign out_product_coeff = signed'(product_bits);

endmodule

// ===== src/pm_checker.sv =====
module pm_checker
  import pm_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_func,
  input logic signed [PM_COEFF_W-1:0] in_coeff_value,
  input logic                         in_last_coeff,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [PM_SUM_W-1:0]   out_product_coeff,
  input logic [PM_POW_W-1:0]          out_power,
  input logic                         out_last_term,
  input logic                         out_truncated
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_coeff)
      && $stable(out_power) && $stable(out_last_term) && $stable(out_truncated))
    else $error("stalled result changed");

  // Drop any result on reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Advance power by one between back-to-back results of one product.
  a_power_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_term) ##1 (out_valid && out_ready)
      |-> out_power == PM_POW_W'($past(out_power) + PM_POW_W'(1)))
    else $error("product powers not consecutive");

  // Hold the truncated flag across one product.
  a_trunc_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_term) ##1 (out_valid && out_ready)
      |-> out_truncated == $past(out_truncated))
    else $error("truncated flag changed within a product");

endmodule

bind polynomial_multiply pm_checker u_pm_checker (.*);
